>>> src/sips_pkg.sv
// Shared constants and types of the sorted insert priority stack.
`timescale 1ns / 1ps
package sips_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OUT_CNT_W = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_e;

  typedef struct packed {
    logic                    ins;
    logic                    pop;
    logic signed [VAL_W-1:0] value;
  } cell_op_t;

endpackage

>>> src/sips_if.sv
// Handshake channels carrying items into and results out of the stack.
`timescale 1ns / 1ps
interface sips_in_if;
  import sips_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface sips_out_if;
  import sips_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] popped_value;
  logic [OUT_CNT_W-1:0]    entry_count;
  logic                    empty_error;
  logic                    full_error;
  modport source (output valid, output popped_value, output entry_count,
                  output empty_error, output full_error, input ready);
  modport sink (input valid, input popped_value, input entry_count,
                input empty_error, input full_error, output ready);
endinterface

>>> src/sips_cell.sv
// One slot of the sorted row: holds an entry and shifts it with its neighbours.
`timescale 1ns / 1ps
module sips_cell
  import sips_pkg::*;
(
  input  logic                    clk_i,
  input  cell_op_t                op_i,
  input  logic                    occ_i,
  input  logic                    left_lt_i,
  input  logic signed [VAL_W-1:0] left_entry_i,
  input  logic signed [VAL_W-1:0] right_entry_i,
  output logic                    lt_o,
  output logic signed [VAL_W-1:0] entry_o
);

  logic signed [VAL_W-1:0] entry_q, entry_d;

  assign lt_o    = occ_i && (entry_q < op_i.value);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (!lt_o) begin
        entry_d = left_lt_i ? op_i.value : left_entry_i;
      end
    end else if (op_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> src/sorted_insert_priority_stack.sv
// Top level of the sorted insert priority stack: cell row, count and result register.
`timescale 1ns / 1ps
// Takes one insert or pop transaction per cycle and returns one result for each,
// in the next cycle, from an output register; a new transaction is taken while a
// result waits only if that result is taken in the same cycle. The entries sit in
// a row of DEPTH cells, smallest at the top; every cell compares its entry with
// the inserted value in parallel and shifts down or up by one slot with its
// neighbours, so the cell compare sets the cycle. No clearing pass after reset.
module sorted_insert_priority_stack
  import sips_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sips_in_if.sink   in_i,
  sips_out_if.source out_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic [OUT_CNT_W-1:0]    out_count_q;
  logic             out_empty_q, out_full_q;

  logic     accept, is_full, is_empty, do_ins, do_pop;
  cell_op_t op;

  logic                    cell_lt    [DEPTH];
  logic signed [VAL_W-1:0] cell_entry [DEPTH];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (count_q >= CNT_W'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign do_ins     = accept && (in_i.kind == KIND_INSERT) && !is_full;
  assign do_pop     = accept && (in_i.kind == KIND_POP) && !is_empty;

  assign op.ins   = do_ins;
  assign op.pop   = do_pop;
  assign op.value = in_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_lt;
    logic signed [VAL_W-1:0] left_entry, right_entry;
    if (i == 0) begin : g_top
      assign left_lt    = 1'b1;
      assign left_entry = in_i.value;
    end else begin : g_mid
      assign left_lt    = cell_lt[i-1];
      assign left_entry = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign right_entry = '0;
    end else begin : g_up
      assign right_entry = cell_entry[i+1];
    end
    sips_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .occ_i         (count_q > CNT_W'(i)),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .lt_o          (cell_lt[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= do_pop ? cell_entry[0] : '0;
      out_count_q <= OUT_CNT_W'(count_d);
      out_empty_q <= (in_i.kind == KIND_POP) && is_empty;
      out_full_q  <= (in_i.kind == KIND_INSERT) && is_full;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = out_value_q;
  assign out_o.entry_count  = out_count_q;
  assign out_o.empty_error  = out_empty_q;
  assign out_o.full_error   = out_full_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("stored count beyond depth");

  a_top_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_entry[0] <= cell_entry[1]))
    else $error("top two entries out of order");

  a_pop_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (out_o.popped_value == $past(cell_entry[0])))
    else $error("popped value is not the old top entry");

  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_count_q == OUT_CNT_W'(count_q)))
    else $error("reported count differs from stored count");

  a_full_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_full_q) |-> (count_q == CNT_W'(DEPTH)))
    else $error("full flag with room left");

endmodule

>>> bench/sorted_insert_priority_stack_tb.sv
// Self-checking testbench of the sorted insert priority stack: directed table, random traffic.
`timescale 1ns / 1ps
module sorted_insert_priority_stack_tb;
  import sips_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned LONG_HOLD = 90;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic [OUT_CNT_W-1:0]    entry_count;
    logic                    empty_error;
    logic                    full_error;
  } stack_result_t;

  typedef struct {
    kind_e                   kind;
    logic signed [VAL_W-1:0] value;
    bit                      typed_in;
    stack_result_t           result;
  } stimulus_row_t;

  typedef enum int {
    RX_STEADY,
    RX_PATTERN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  sips_in_if  in_ch ();
  sips_out_if out_ch ();

  sorted_insert_priority_stack dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic signed [VAL_W-1:0] sorted_vals [DEPTH];
  int unsigned             held_count;
  stack_result_t           pending_results [$];
  stimulus_row_t           directed_rows [$];
  int unsigned             error_count;
  int unsigned             cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic stack_result_t apply_item(kind_e kind, logic signed [VAL_W-1:0] value);
    stack_result_t res;
    int unsigned   pos;
    res = '0;
    if (kind == KIND_INSERT) begin
      if (held_count >= DEPTH) begin
        res.full_error = 1'b1;
      end else begin
        pos = 0;
        while (pos < held_count && sorted_vals[pos] < value) pos++;
        for (int unsigned j = held_count; j > pos; j--) sorted_vals[j] = sorted_vals[j-1];
        sorted_vals[pos] = value;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.empty_error = 1'b1;
      end else begin
        res.popped_value = sorted_vals[0];
        for (int unsigned j = 1; j < held_count; j++) sorted_vals[j-1] = sorted_vals[j];
        held_count--;
      end
    end
    res.entry_count = held_count[OUT_CNT_W-1:0];
    return res;
  endfunction

  function automatic stack_result_t typed_result(logic signed [VAL_W-1:0] popped,
                                                 int unsigned count, bit empty_err,
                                                 bit full_err);
    stack_result_t res;
    res.popped_value = popped;
    res.entry_count  = count[OUT_CNT_W-1:0];
    res.empty_error  = empty_err;
    res.full_error   = full_err;
    return res;
  endfunction

  function automatic void add_row(kind_e kind, logic signed [VAL_W-1:0] value,
                                  bit typed_in = 1'b0, stack_result_t result = '0);
    stimulus_row_t row;
    row.kind     = kind;
    row.value    = value;
    row.typed_in = typed_in;
    row.result   = result;
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1, 5: v = $urandom;
      2:       v = $signed($urandom_range(0, 15)) - 8;
      3:       v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
    return v;
  endfunction

  task automatic offer_item(kind_e kind, logic signed [VAL_W-1:0] value,
                            bit typed_in, stack_result_t typed);
    stack_result_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = apply_item(kind, value);
    pending_results.push_back(typed_in ? typed : predicted);
  endtask

  task automatic idle_sender(int unsigned cycles);
    in_ch.valid <= 1'b0;
    in_ch.kind  <= 1'($urandom_range(0, 1));
    in_ch.value <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst_left;
    int unsigned segment_left;
    int unsigned insert_pct;
    int unsigned pct_choices [5];
    kind_e       kind;
    pct_choices  = '{0, 15, 50, 85, 100};
    held_count   = 0;
    error_count  = 0;
    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_INSERT;
    in_ch.value <= '0;

    add_row(KIND_POP, 32'sh0000_0000, 1'b1, typed_result(0, 0, 1'b1, 1'b0));
    add_row(KIND_INSERT, 32'sh7FFF_FFFF, 1'b1, typed_result(0, 1, 1'b0, 1'b0));
    add_row(KIND_INSERT, 32'sh8000_0000, 1'b1, typed_result(0, 2, 1'b0, 1'b0));
    add_row(KIND_INSERT, 32'sh0000_0000);
    add_row(KIND_INSERT, 32'sh0000_0000);
    add_row(KIND_POP, 32'sh1234_5678, 1'b1, typed_result(32'sh8000_0000, 3, 1'b0, 1'b0));
    add_row(KIND_INSERT, 32'sh5555_5555);
    add_row(KIND_INSERT, 32'shAAAA_AAAA);
    add_row(KIND_INSERT, -32'sd1);
    add_row(KIND_INSERT, 32'sd1);
    add_row(KIND_INSERT, 32'sd5);
    add_row(KIND_INSERT, 32'sd5);
    add_row(KIND_INSERT, -32'sd7);
    add_row(KIND_INSERT, 32'sd42);
    add_row(KIND_INSERT, 32'sh7FFF_FFFE);
    add_row(KIND_INSERT, 32'sh8000_0001);
    add_row(KIND_INSERT, 32'sd0);
    add_row(KIND_INSERT, 32'sd3);
    add_row(KIND_INSERT, -32'sd3);
    add_row(KIND_INSERT, 32'sd9, 1'b1, typed_result(0, DEPTH, 1'b0, 1'b1));
    add_row(KIND_POP, 32'shFFFF_FFFF);
    add_row(KIND_INSERT, 32'sh7FFF_FFFF);
    add_row(KIND_INSERT, 32'sh8000_0000, 1'b1, typed_result(0, DEPTH, 1'b0, 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed_in,
                 directed_rows[i].result);
    end

    sent         = 0;
    burst_left   = $urandom_range(1, 20);
    segment_left = 0;
    insert_pct   = 50;
    while (sent < RANDOM_ITEMS) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(10, 60);
        insert_pct   = pct_choices[$urandom_range(0, 4)];
      end
      kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP;
      offer_item(kind, pick_value(), 1'b0, '0);
      sent++;
      segment_left--;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
      end
    end
    idle_sender(0);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (error_count == 0) begin
      $display("sorted_insert_priority_stack_tb: done, clean");
    end else begin
      $display("sorted_insert_priority_stack_tb: done, errors");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned   stretch;
    int unsigned   stretch_idx;
    logic [31:0]   pattern;
    rx_mode_e      mode;
    stretch_idx     = 0;
    out_ch.ready   <= 1'b0;
    forever begin
      stretch = $urandom_range(20, 120);
      stretch_idx++;
      if (stretch_idx == 6 || stretch_idx == 25) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        pattern = $urandom;
        for (int unsigned i = 0; i < stretch; i++) begin
          case (mode)
            RX_STEADY:  out_ch.ready <= 1'b1;
            RX_PATTERN: out_ch.ready <= pattern[i % 32];
            RX_MOSTLY:  out_ch.ready <= ($urandom_range(0, 3) != 0);
            default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    stack_result_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.popped_value !== exp_res.popped_value) begin
          $error("popped_value: expected %0d, actual %0d", exp_res.popped_value,
                 out_ch.popped_value);
          error_count++;
        end
        if (out_ch.entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_res.entry_count,
                 out_ch.entry_count);
          error_count++;
        end
        if (out_ch.empty_error !== exp_res.empty_error) begin
          $error("empty_error: expected %0b, actual %0b", exp_res.empty_error,
                 out_ch.empty_error);
          error_count++;
        end
        if (out_ch.full_error !== exp_res.full_error) begin
          $error("full_error: expected %0b, actual %0b", exp_res.full_error,
                 out_ch.full_error);
          error_count++;
        end
      end
    end
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_insert_priority_stack_tb: done, errors");
      $finish;
    end
  end

endmodule
